@@ rtl/mecanum_wheel_odometry_assert.svh @@
// assertion macros for the mecanum wheel odometry block
// used by mecanum_wheel_odometry.sv, no other dependencies
`ifndef MECANUM_WHEEL_ODOMETRY_ASSERT_SVH
`define MECANUM_WHEEL_ODOMETRY_ASSERT_SVH

// condition holds at every edge out of reset
`define MWO_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("mwo invariant violated");

// consequence holds in the same cycle as the trigger
`define MWO_ASSERT_IMPLY(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("mwo implication violated");

// consequence holds in the cycle after the trigger
`define MWO_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("mwo sequence violated");

`endif

@@ rtl/mwo_pkg.sv @@
// shared types, constants and helper functions for mecanum wheel odometry
// no dependencies; imported by mecanum_wheel_odometry
package mwo_pkg;

   localparam int unsigned ANGLE_W    = 32;
   localparam int unsigned TIME_W     = 48;
   localparam int unsigned CFG_W      = 25;
   localparam int unsigned KIND_W     = 2;

   // shared unit widths
   localparam int unsigned PROD_W     = 66;
   localparam int unsigned NUM_W      = 60;
   localparam int unsigned DEN_W      = 48;
   localparam int unsigned CNT_W      = 6;
   localparam int unsigned MUL_STEPS  = 31;
   localparam int unsigned DIV_STEPS  = 60;

   // cordic datapath
   localparam int unsigned CORDIC_W     = 42;
   localparam int unsigned Z_W          = 33;
   localparam int unsigned ITER_W       = 5;
   localparam int unsigned CORDIC_STEPS = 30;

   localparam int unsigned SUM_W      = 40;
   localparam int unsigned WINDOW_DEPTH_DEF = 8;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_UPDATE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INIT       = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESET_POSE = 2'd2;

   // register indexes
   localparam logic CSR_WHEEL_RADIUS   = 1'b0;
   localparam logic CSR_WHEEL_BASE_SUM = 1'b1;

   localparam logic [CFG_W-1:0] RADIUS_RESET = 25'd3277;
   localparam logic [CFG_W-1:0] BASE_RESET   = 25'd32768;

   localparam logic [TIME_W-1:0] MIN_INTERVAL_US = 48'd100;
   localparam logic [30:0] HEAD_SCALE  = 31'd683565276;
   localparam logic [30:0] CORDIC_GAIN = 31'd1304065748;
   localparam logic [30:0] VEL_SCALE   = 31'd1000000;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [ANGLE_W-1:0] front_left_angle;
      logic signed [ANGLE_W-1:0] front_right_angle;
      logic signed [ANGLE_W-1:0] rear_left_angle;
      logic signed [ANGLE_W-1:0] rear_right_angle;
      logic [TIME_W-1:0]         time_us;
   } mwo_req_type;

   typedef struct packed {
      logic                      accepted;
      logic signed [ANGLE_W-1:0] pose_x;
      logic signed [ANGLE_W-1:0] pose_y;
      logic [ANGLE_W-1:0]        pose_heading;
      logic signed [ANGLE_W-1:0] mean_vel_x;
      logic signed [ANGLE_W-1:0] mean_vel_y;
      logic signed [ANGLE_W-1:0] mean_turn_rate;
   } mwo_rsp_type;

   // arctangent of 2^-i as binary angle, 2^32 per turn
   function automatic logic [29:0] atan_lookup(input logic [ITER_W-1:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2FA;
         5'd15: v = 30'h0000517D;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A30;
         5'd19: v = 30'h00000518;
         5'd20: v = 30'h0000028C;
         5'd21: v = 30'h00000146;
         5'd22: v = 30'h000000A3;
         5'd23: v = 30'h00000051;
         5'd24: v = 30'h00000029;
         5'd25: v = 30'h00000014;
         5'd26: v = 30'h0000000A;
         5'd27: v = 30'h00000005;
         5'd28: v = 30'h00000003;
         5'd29: v = 30'h00000001;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

   // signed 32 bit value from sign and magnitude, saturating
   function automatic logic signed [31:0] sat_mag(input logic neg,
                                                  input logic [PROD_W-1:0] mag);
      logic signed [31:0] r;
      if (!neg) begin
         r = (mag > 66'h7FFFFFFF) ? 32'sh7FFFFFFF : signed'(mag[31:0]);
      end else begin
         r = (mag > 66'h80000000) ? 32'sh80000000 : signed'(~mag[31:0] + 32'd1);
      end
      return r;
   endfunction

   // saturate a 36 bit sum to signed 32 bit
   function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [34:0] mag35(input logic signed [34:0] v);
      return v[34] ? 35'(-v) : 35'(v);
   endfunction

   function automatic logic [SUM_W-1:0] mag40(input logic signed [SUM_W-1:0] v);
      return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
   endfunction

endpackage

@@ rtl/mecanum_wheel_odometry.sv @@
// mecanum wheel odometry: an update word is worked out by nine shift-add multiplies and
// seven restoring divides on one shared unit plus a 30-step cordic; init, reset pose,
// refused and unknown words go straight to the finish state. a new word is accepted the
// cycle after the previous result is queued.
// synchronous active-high reset restores register defaults, zero pose and empty windows.
// depends on mwo_pkg and mecanum_wheel_odometry_assert.svh
`include "mecanum_wheel_odometry_assert.svh"

module mecanum_wheel_odometry
   import mwo_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mwo_req_type       req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mwo_rsp_type       rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_RUN    = 7'b0000010,
      ST_POST   = 7'b0000100,
      ST_CORDIC = 7'b0001000,
      ST_MEM_RD = 7'b0010000,
      ST_PUSH   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   typedef enum logic [3:0] {
      STEP_MUL_X  = 4'd0,
      STEP_MUL_Y  = 4'd1,
      STEP_MUL_A  = 4'd2,
      STEP_DIV_A  = 4'd3,
      STEP_MUL_H  = 4'd4,
      STEP_MUL_GX = 4'd5,
      STEP_MUL_GY = 4'd6,
      STEP_ROT    = 4'd7,
      STEP_MUL_V  = 4'd8,
      STEP_DIV_V  = 4'd9,
      STEP_DIV_M  = 4'd10
   } step_type;

   // sequencer and shared unit
   state_type                  state_ff, state_in;
   step_type                   step_ff, step_in;
   logic [1:0]                 k_ff, k_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       div_mode_ff, div_mode_in;
   logic                       neg_ff, neg_in;
   logic [PROD_W-1:0]          mc_ff, mc_in;
   logic [PROD_W-1:0]          acc_ff, acc_in;
   logic [DEN_W-1:0]           mp_ff, mp_in;

   // per-word working values
   logic signed [34:0]         sy_ff, sy_in, sa_ff, sa_in;
   logic [TIME_W-1:0]          dt_ff, dt_in;
   logic signed [31:0]         dx_ff, dx_in, dy_ff, dy_in, da_ff, da_in;
   logic signed [CORDIC_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [Z_W-1:0]      cz_ff, cz_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic signed [31:0]         vel_ff [3];
   logic signed [31:0]         vel_in [3];
   logic                       acc_flag_ff, acc_flag_in;

   // architectural state
   logic [CFG_W-1:0]           radius_ff, radius_in, base_ff, base_in;
   logic signed [31:0]         ang_ff [4];
   logic signed [31:0]         ang_in [4];
   logic [TIME_W-1:0]          last_time_ff, last_time_in;
   logic signed [31:0]         pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [31:0]                head_ff, head_in;
   logic signed [SUM_W-1:0]    sum_ff [3];
   logic signed [SUM_W-1:0]    sum_in [3];
   logic signed [31:0]         mean_ff [3];
   logic signed [31:0]         mean_in [3];
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;

   // velocity windows
   logic signed [31:0]         win_mem [3][WINDOW_DEPTH];
   logic signed [31:0]         rd_data_ff;

   mwo_rsp_type                rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign csr_ready = 1'b1;

   // sequencer, shared unit and state updates
   always_comb begin
      logic [TIME_W:0]            elapsed;
      logic                       t_ok;
      logic signed [32:0]         wd [4];
      logic signed [31:0]         wnow [4];
      logic signed [34:0]         s_x;
      logic [CFG_W-1:0]           sep;
      logic [CFG_W+1:0]           sep4;
      logic [PROD_W-1:0]          r18, g23, bam;
      logic signed [31:0]         r18_sat, quo_sat, inc_next;
      logic signed [CORDIC_W-1:0] g_signed, xs, ys;
      logic signed [Z_W-1:0]      at_s;
      logic [31:0]                hsum, hq;
      logic signed [33:0]         rx, ry;
      logic [DEN_W:0]             rem_sh;
      logic                       ge;
      logic                       full;
      logic [FILL_W-1:0]          fill_next;
      logic [SLOT_W-1:0]          slot_next;
      logic signed [SUM_W-1:0]    old_val;
      logic [1:0]                 k_up;
      logic                       ld_en, ld_div, ld_neg;
      logic [NUM_W-1:0]           ld_num;
      logic [DEN_W-1:0]           ld_den;

      state_in     = state_ff;
      step_in      = step_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      div_mode_in  = div_mode_ff;
      neg_in       = neg_ff;
      mc_in        = mc_ff;
      acc_in       = acc_ff;
      mp_in        = mp_ff;
      sy_in        = sy_ff;
      sa_in        = sa_ff;
      dt_in        = dt_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      da_in        = da_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      iter_in      = iter_ff;
      vel_in       = vel_ff;
      acc_flag_in  = acc_flag_ff;
      radius_in    = radius_ff;
      base_in      = base_ff;
      ang_in       = ang_ff;
      last_time_in = last_time_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ld_en        = 1'b0;
      ld_div       = 1'b0;
      ld_neg       = 1'b0;
      ld_num       = '0;
      ld_den       = '0;

      // interval check and wheel deltas
      elapsed = {1'b0, req_word.time_us} - {1'b0, last_time_ff};
      t_ok    = !elapsed[TIME_W] && (elapsed[TIME_W-1:0] >= MIN_INTERVAL_US);
      wnow[0] = req_word.front_left_angle;
      wnow[1] = req_word.front_right_angle;
      wnow[2] = req_word.rear_left_angle;
      wnow[3] = req_word.rear_right_angle;
      for (int i = 0; i < 4; i++) begin
         wd[i] = 33'(wnow[i]) - 33'(ang_ff[i]);
      end
      s_x = 35'(wd[0]) + 35'(wd[1]) + 35'(wd[2]) + 35'(wd[3]);

      sep  = (base_ff == '0) ? CFG_W'(1) : base_ff;
      sep4 = {sep, 2'b00};

      // rounding of unit results, ties away from zero
      r18      = (acc_ff + (66'd1 << 17)) >> 18;
      g23      = (acc_ff + (66'd1 << 22)) >> 23;
      bam      = (acc_ff + (66'd1 << 31)) >> 32;
      r18_sat  = sat_mag(neg_ff, r18);
      quo_sat  = sat_mag(neg_ff, PROD_W'(mc_ff[NUM_W-1:0]));
      g_signed = neg_ff ? -signed'(g23[CORDIC_W-1:0]) : signed'(g23[CORDIC_W-1:0]);
      inc_next = (k_ff == 2'd0) ? dy_ff : da_ff;
      k_up     = k_ff + 2'd1;

      // heading fold into the right half plane
      hsum = head_ff + 32'h40000000;
      hq   = hsum[31] ? (head_ff + 32'h80000000) : head_ff;

      // cordic micro-rotation
      xs   = cx_ff >>> iter_ff;
      ys   = cy_ff >>> iter_ff;
      at_s = signed'(Z_W'(atan_lookup(iter_ff)));

      // back to q16.16 with half-up rounding
      rx = 34'((cx_ff + 42'sd128) >>> 8);
      ry = 34'((cy_ff + 42'sd128) >>> 8);

      // restoring divide step
      rem_sh = {acc_ff[DEN_W-1:0], mc_ff[PROD_W-1]};
      ge     = (rem_sh >= {1'b0, mp_ff});

      // window bookkeeping
      full      = (fill_ff == FILL_W'(WINDOW_DEPTH));
      fill_next = full ? fill_ff : fill_ff + 1'b1;
      slot_next = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
      old_val   = full ? SUM_W'(rd_data_ff) : '0;

      // result word leaves
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_word.kind)
                  KIND_UPDATE: begin
                     if (t_ok) begin
                        for (int i = 0; i < 4; i++) begin
                           ang_in[i] = wnow[i];
                        end
                        sy_in        = -35'(wd[0]) + 35'(wd[1]) + 35'(wd[2]) - 35'(wd[3]);
                        sa_in        = -35'(wd[0]) + 35'(wd[1]) - 35'(wd[2]) + 35'(wd[3]);
                        dt_in        = elapsed[TIME_W-1:0];
                        last_time_in = req_word.time_us;
                        acc_flag_in  = 1'b1;
                        ld_en        = 1'b1;
                        ld_num       = NUM_W'(mag35(s_x));
                        ld_den       = DEN_W'(radius_ff);
                        ld_neg       = s_x[34];
                        step_in      = STEP_MUL_X;
                     end else begin
                        acc_flag_in = 1'b0;
                        state_in    = ST_FINISH;
                     end
                  end
                  KIND_INIT: begin
                     last_time_in = req_word.time_us;
                     for (int i = 0; i < 3; i++) begin
                        sum_in[i]  = '0;
                        mean_in[i] = '0;
                     end
                     fill_in     = '0;
                     slot_in     = '0;
                     acc_flag_in = 1'b1;
                     state_in    = ST_FINISH;
                  end
                  KIND_RESET_POSE: begin
                     pos_x_in    = '0;
                     pos_y_in    = '0;
                     head_in     = '0;
                     acc_flag_in = 1'b1;
                     state_in    = ST_FINISH;
                  end
                  default: begin
                     acc_flag_in = 1'b0;
                     state_in    = ST_FINISH;
                  end
               endcase
            end
         end

         ST_RUN: begin
            if (div_mode_ff) begin
               acc_in = PROD_W'(ge ? (rem_sh - {1'b0, mp_ff}) : rem_sh);
               mc_in  = {mc_ff[PROD_W-2:0], ge};
            end else begin
               acc_in = acc_ff + (mp_ff[0] ? mc_ff : '0);
               mc_in  = mc_ff << 1;
               mp_in  = mp_ff >> 1;
            end
            if (cnt_ff == '0) begin
               state_in = ST_POST;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         ST_POST: begin
            case (step_ff)
               STEP_MUL_X: begin
                  dx_in   = r18_sat;
                  ld_en   = 1'b1;
                  ld_num  = NUM_W'(mag35(sy_ff));
                  ld_den  = DEN_W'(radius_ff);
                  ld_neg  = sy_ff[34];
                  step_in = STEP_MUL_Y;
               end
               STEP_MUL_Y: begin
                  dy_in   = r18_sat;
                  ld_en   = 1'b1;
                  ld_num  = NUM_W'(mag35(sa_ff));
                  ld_den  = DEN_W'(radius_ff);
                  ld_neg  = sa_ff[34];
                  step_in = STEP_MUL_A;
               end
               STEP_MUL_A: begin
                  ld_en   = 1'b1;
                  ld_div  = 1'b1;
                  ld_num  = acc_ff[NUM_W-1:0] + NUM_W'(sep4 >> 1);
                  ld_den  = DEN_W'(sep4);
                  ld_neg  = neg_ff;
                  step_in = STEP_DIV_A;
               end
               STEP_DIV_A: begin
                  da_in   = quo_sat;
                  ld_en   = 1'b1;
                  ld_num  = NUM_W'(mag35(35'(quo_sat)));
                  ld_den  = DEN_W'(HEAD_SCALE);
                  ld_neg  = quo_sat[31];
                  step_in = STEP_MUL_H;
               end
               STEP_MUL_H: begin
                  head_in = neg_ff ? (head_ff - bam[31:0]) : (head_ff + bam[31:0]);
                  ld_en   = 1'b1;
                  ld_num  = NUM_W'(mag35(35'(dx_ff)));
                  ld_den  = DEN_W'(CORDIC_GAIN);
                  ld_neg  = dx_ff[31];
                  step_in = STEP_MUL_GX;
               end
               STEP_MUL_GX: begin
                  cx_in   = g_signed;
                  ld_en   = 1'b1;
                  ld_num  = NUM_W'(mag35(35'(dy_ff)));
                  ld_den  = DEN_W'(CORDIC_GAIN);
                  ld_neg  = dy_ff[31];
                  step_in = STEP_MUL_GY;
               end
               STEP_MUL_GY: begin
                  cx_in    = hsum[31] ? -cx_ff : cx_ff;
                  cy_in    = hsum[31] ? -g_signed : g_signed;
                  cz_in    = Z_W'(signed'(hq));
                  iter_in  = '0;
                  step_in  = STEP_ROT;
                  state_in = ST_CORDIC;
               end
               STEP_ROT: begin
                  pos_x_in = sat36(36'(pos_x_ff) + 36'(rx));
                  pos_y_in = sat36(36'(pos_y_ff) + 36'(ry));
                  k_in     = 2'd0;
                  ld_en    = 1'b1;
                  ld_num   = NUM_W'(mag35(35'(dx_ff)));
                  ld_den   = DEN_W'(VEL_SCALE);
                  ld_neg   = dx_ff[31];
                  step_in  = STEP_MUL_V;
               end
               STEP_MUL_V: begin
                  ld_en   = 1'b1;
                  ld_div  = 1'b1;
                  ld_num  = acc_ff[NUM_W-1:0] + NUM_W'(dt_ff >> 1);
                  ld_den  = dt_ff;
                  ld_neg  = neg_ff;
                  step_in = STEP_DIV_V;
               end
               STEP_DIV_V: begin
                  vel_in[k_ff] = quo_sat;
                  if (k_ff != 2'd2) begin
                     k_in    = k_up;
                     ld_en   = 1'b1;
                     ld_num  = NUM_W'(mag35(35'(inc_next)));
                     ld_den  = DEN_W'(VEL_SCALE);
                     ld_neg  = inc_next[31];
                     step_in = STEP_MUL_V;
                  end else begin
                     k_in     = 2'd0;
                     state_in = ST_MEM_RD;
                  end
               end
               STEP_DIV_M: begin
                  mean_in[k_ff] = quo_sat;
                  if (k_ff != 2'd2) begin
                     k_in    = k_up;
                     ld_en   = 1'b1;
                     ld_div  = 1'b1;
                     ld_num  = NUM_W'(mag40(sum_ff[k_up])) + NUM_W'(fill_ff >> 1);
                     ld_den  = DEN_W'(fill_ff);
                     ld_neg  = sum_ff[k_up][SUM_W-1];
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         ST_CORDIC: begin
            if (!cz_ff[Z_W-1]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at_s;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at_s;
            end
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_POST;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end

         ST_MEM_RD: begin
            state_in = ST_PUSH;
         end

         ST_PUSH: begin
            sum_in[k_ff] = sum_ff[k_ff] - old_val + SUM_W'(vel_ff[k_ff]);
            if (k_ff != 2'd2) begin
               k_in     = k_up;
               state_in = ST_MEM_RD;
            end else begin
               fill_in = fill_next;
               slot_in = slot_next;
               k_in    = 2'd0;
               ld_en   = 1'b1;
               ld_div  = 1'b1;
               ld_num  = NUM_W'(mag40(sum_ff[0])) + NUM_W'(fill_next >> 1);
               ld_den  = DEN_W'(fill_next);
               ld_neg  = sum_ff[0][SUM_W-1];
               step_in = STEP_DIV_M;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.accepted       = acc_flag_ff;
               rsp_in.pose_x         = pos_x_ff;
               rsp_in.pose_y         = pos_y_ff;
               rsp_in.pose_heading   = head_ff;
               rsp_in.mean_vel_x     = mean_ff[0];
               rsp_in.mean_vel_y     = mean_ff[1];
               rsp_in.mean_turn_rate = mean_ff[2];
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // start the shared unit
      if (ld_en) begin
         state_in    = ST_RUN;
         div_mode_in = ld_div;
         neg_in      = ld_neg;
         acc_in      = '0;
         mp_in       = ld_den;
         if (ld_div) begin
            mc_in  = {ld_num, (PROD_W - NUM_W)'(0)};
            cnt_in = CNT_W'(DIV_STEPS - 1);
         end else begin
            mc_in  = PROD_W'(ld_num);
            cnt_in = CNT_W'(MUL_STEPS - 1);
         end
      end

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_WHEEL_RADIUS:   radius_in = csr_wdata;
            CSR_WHEEL_BASE_SUM: base_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_MUL_X;
         k_ff         <= '0;
         cnt_ff       <= '0;
         div_mode_ff  <= 1'b0;
         radius_ff    <= RADIUS_RESET;
         base_ff      <= BASE_RESET;
         ang_ff       <= '{default: '0};
         last_time_ff <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
         sum_ff       <= '{default: '0};
         mean_ff      <= '{default: '0};
         fill_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         div_mode_ff  <= div_mode_in;
         radius_ff    <= radius_in;
         base_ff      <= base_in;
         ang_ff       <= ang_in;
         last_time_ff <= last_time_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
         sum_ff       <= sum_in;
         mean_ff      <= mean_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      mc_ff       <= mc_in;
      acc_ff      <= acc_in;
      mp_ff       <= mp_in;
      sy_ff       <= sy_in;
      sa_ff       <= sa_in;
      dt_ff       <= dt_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      da_ff       <= da_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      iter_ff     <= iter_in;
      vel_ff      <= vel_in;
      acc_flag_ff <= acc_flag_in;
      rsp_ff      <= rsp_in;
   end

   // window memory, registered read of the slot being replaced
   always_ff @(posedge clock) begin
      if (state_ff == ST_PUSH) begin
         win_mem[k_ff][slot_ff] <= vel_ff[k_ff];
      end
      rd_data_ff <= win_mem[k_ff][slot_ff];
   end

   `MWO_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FILL_W'(WINDOW_DEPTH))
   `MWO_ASSERT_IMPLY(a_empty_mean_zero, clock, reset, fill_ff == '0, mean_ff[0] == '0 && mean_ff[1] == '0 && mean_ff[2] == '0)
   `MWO_ASSERT_IMPLY(a_cordic_iter, clock, reset, state_ff == ST_CORDIC, iter_ff < ITER_W'(CORDIC_STEPS))
   `MWO_ASSERT_NEXT(a_finish_loads, clock, reset, state_ff == ST_FINISH && !(rsp_valid_ff && rsp_stall), rsp_valid_ff && state_ff == ST_IDLE)

endmodule

@@ tb/sv/mecanum_wheel_odometry_test.sv @@
// testbench for mecanum_wheel_odometry: directed words, register sweeps, random
// drives with back-pressure; depends on mwo_pkg and the block's rtl only
module mecanum_wheel_odometry_test
   import mwo_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 8;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int LONG_HOLD = 3000;
   localparam longint TICK = 64'sd1 <<< 16;

   // kind code with no meaning, must be refused
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // arctangent table for the rotation, binary angle 2^32 per turn
   localparam longint ATAN_BAM [30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mwo_req_type       req_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mwo_rsp_type       rsp_word;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = CSR_WHEEL_RADIUS;
   logic [CFG_W-1:0]  csr_wdata = '0;

   mecanum_wheel_odometry DUT (.*);

   always #10 clock = ~clock;

   // predictor state
   longint      radius_q16;
   longint      base_q16;
   longint      prev_angle [4];
   logic [47:0] ref_time;
   longint      pos [2];
   logic [31:0] heading;
   longint      vel_win [3][DEPTH];
   longint      vel_sum [3];
   int          fill_cnt;
   int          write_slot;

   mwo_rsp_type expected_poses [$];
   int          failures = 0;
   int          words_sent = 0;
   int          updates_taken = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;
   bit          hold_ask = 1'b0;
   int          hold_left = 0;
   int          stall_run = 0;

   // stimulus-side trajectory
   logic [47:0] stim_time;
   logic [31:0] stim_angle [4];

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // round to nearest, ties away from zero
   function automatic longint rdiv(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic void clear_windows();
      for (int k = 0; k < 3; k++) begin
         vel_sum[k] = 0;
         for (int j = 0; j < DEPTH; j++) vel_win[k][j] = 0;
      end
      fill_cnt = 0;
      write_slot = 0;
   endfunction

   // rotate body displacement by binary angle, gain-corrected cordic
   function automatic void rotate_by_heading(longint vx, longint vy, logic [31:0] h,
                                             output longint ox, output longint oy);
      longint x, y, z, xs, ys;
      logic [31:0] hq, probe;
      x = rdiv(vx * 64'sd1304065748, 64'sd1 <<< 23);
      y = rdiv(vy * 64'sd1304065748, 64'sd1 <<< 23);
      hq = h;
      probe = hq + 32'h40000000;
      if (probe[31]) begin
         x = -x;
         y = -y;
         hq = hq + 32'h80000000;
      end
      z = longint'(signed'(hq));
      for (int i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ATAN_BAM[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ATAN_BAM[i];
         end
      end
      ox = (x + 128) >>> 8;
      oy = (y + 128) >>> 8;
   endfunction

   // next pose and window means for one word, accepted or refused
   function automatic mwo_rsp_type predict_odometry(mwo_req_type w);
      mwo_rsp_type r;
      longint a [4], d [4], v [3];
      longint dx, dy, da, dt, sep, rx, ry, head_step;
      bit taken;
      taken = 1'b0;
      if (w.kind == KIND_UPDATE) begin
         if (w.time_us >= ref_time && (w.time_us - ref_time) >= MIN_INTERVAL_US) begin
            a[0] = longint'(w.front_left_angle);
            a[1] = longint'(w.front_right_angle);
            a[2] = longint'(w.rear_left_angle);
            a[3] = longint'(w.rear_right_angle);
            for (int k = 0; k < 4; k++) begin
               d[k] = a[k] - prev_angle[k];
               prev_angle[k] = a[k];
            end
            sep = (base_q16 == 0) ? 1 : base_q16;
            dt = longint'(w.time_us - ref_time);
            dx = sat32(rdiv(radius_q16 * (d[0] + d[1] + d[2] + d[3]), 4 * TICK));
            dy = sat32(rdiv(radius_q16 * (-d[0] + d[1] + d[2] - d[3]), 4 * TICK));
            da = sat32(rdiv(radius_q16 * (-d[0] + d[1] - d[2] + d[3]), 4 * sep));
            head_step = rdiv(da * 64'sd683565276, 64'sd1 <<< 32);
            heading = heading + head_step[31:0];
            rotate_by_heading(dx, dy, heading, rx, ry);
            pos[0] = sat32(pos[0] + rx);
            pos[1] = sat32(pos[1] + ry);
            ref_time = w.time_us;
            v[0] = sat32(rdiv(dx * 1000000, dt));
            v[1] = sat32(rdiv(dy * 1000000, dt));
            v[2] = sat32(rdiv(da * 1000000, dt));
            for (int k = 0; k < 3; k++) begin
               if (fill_cnt >= DEPTH) vel_sum[k] -= vel_win[k][write_slot];
               vel_sum[k] += v[k];
               vel_win[k][write_slot] = v[k];
            end
            if (fill_cnt < DEPTH) fill_cnt++;
            write_slot = (write_slot + 1) % DEPTH;
            taken = 1'b1;
            updates_taken++;
         end
      end else if (w.kind == KIND_INIT) begin
         ref_time = w.time_us;
         clear_windows();
         taken = 1'b1;
      end else if (w.kind == KIND_RESET_POSE) begin
         pos[0] = 0;
         pos[1] = 0;
         heading = '0;
         taken = 1'b1;
      end
      r.accepted = taken;
      r.pose_x = pos[0][31:0];
      r.pose_y = pos[1][31:0];
      r.pose_heading = heading;
      r.mean_vel_x = fill_cnt ? 32'(sat32(rdiv(vel_sum[0], fill_cnt))) : '0;
      r.mean_vel_y = fill_cnt ? 32'(sat32(rdiv(vel_sum[1], fill_cnt))) : '0;
      r.mean_turn_rate = fill_cnt ? 32'(sat32(rdiv(vel_sum[2], fill_cnt))) : '0;
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // receiver stall: long hold on request, otherwise random runs
   always @(posedge clock) begin
      if (hold_left == 0 && hold_ask) begin
         hold_left = LONG_HOLD;
         hold_ask = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else begin
         stall_run = pick_gap();
         rsp_stall <= (stall_run > 0);
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         failures++;
      end
   endtask

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      mwo_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_poses.size() == 0) begin
            $error("result word with no prediction pending");
            failures++;
         end else begin
            e = expected_poses.pop_front();
            check_field("accepted", 32'(e.accepted), 32'(rsp_word.accepted));
            check_field("pose_x", e.pose_x, rsp_word.pose_x);
            check_field("pose_y", e.pose_y, rsp_word.pose_y);
            check_field("pose_heading", e.pose_heading, rsp_word.pose_heading);
            check_field("mean_vel_x", e.mean_vel_x, rsp_word.mean_vel_x);
            check_field("mean_vel_y", e.mean_vel_y, rsp_word.mean_vel_y);
            check_field("mean_turn_rate", e.mean_turn_rate, rsp_word.mean_turn_rate);
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_word(mwo_req_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      expected_poses.push_back(predict_odometry(w));
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [CFG_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_WHEEL_RADIUS) radius_q16 = longint'(value);
      else base_q16 = longint'(value);
   endtask

   function automatic mwo_req_type make_word(logic [1:0] kind, logic [31:0] fl,
                                             logic [31:0] fr, logic [31:0] rl,
                                             logic [31:0] rr, logic [47:0] t);
      mwo_req_type w;
      w.kind = kind;
      w.front_left_angle = fl;
      w.front_right_angle = fr;
      w.rear_left_angle = rl;
      w.rear_right_angle = rr;
      w.time_us = t;
      return w;
   endfunction

   // well-formed motion step: time advances, wheels turn by up to the given spread
   task automatic send_motion(int spread);
      logic [31:0] step;
      stim_time = stim_time + $urandom_range(100, 5000);
      for (int k = 0; k < 4; k++) begin
         step = $urandom_range(0, spread);
         stim_angle[k] = $urandom_range(0, 1) ? stim_angle[k] + step
                                               : stim_angle[k] - step;
      end
      send_word(make_word(KIND_UPDATE, stim_angle[0], stim_angle[1], stim_angle[2],
                          stim_angle[3], stim_time));
   endtask

   task automatic send_init(logic [47:0] t);
      stim_time = t;
      send_word(make_word(KIND_INIT, $urandom, $urandom, $urandom, $urandom, t));
   endtask

   task automatic test_directed();
      send_init(48'd1000);
      send_word(make_word(KIND_UPDATE, 32'd5, 32'd5, 32'd5, 32'd5, 48'd1099));
      send_word(make_word(KIND_UPDATE, 32'd5, 32'd5, 32'd5, 32'd5, 48'd500));
      send_word(make_word(KIND_UPDATE, 32'h7FFFFFFF, 32'h80000000, 32'd0,
                          32'hFFFFFFFF, 48'd1100));
      send_word(make_word(KIND_UPDATE, '0, '0, '0, '0, 48'd1300));
      send_word(make_word(KIND_UPDATE, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
                          48'd1400));
      send_word(make_word(KIND_UPDATE, '0, 32'h30000, '0, 32'h30000, 48'd2400));
      send_word(make_word(KIND_UNUSED, 32'hFFFFFFFF, '0, 32'hFFFFFFFF, '0, '1));
      send_word(make_word(KIND_RESET_POSE, '0, '0, '0, '0, '0));
      send_word(make_word(KIND_UPDATE, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                          32'h7FFFFFFF, 48'hFFFF_FFFF_FFFF));
      send_word(make_word(KIND_UPDATE, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF));
      send_init(48'hFFFF_FFFF_FFFF);
      send_init(48'd0);
      for (int k = 0; k < 4; k++) stim_angle[k] = '0;
      send_word(make_word(KIND_UPDATE, '0, '0, '0, '0, 48'd100));
      stim_time = 48'd100;
      wait_drained();
   endtask

   // extreme radius and separation, big wheel swings push saturation
   task automatic test_register_extremes();
      write_register(CSR_WHEEL_RADIUS, 25'd16777216);
      write_register(CSR_WHEEL_BASE_SUM, 25'd1);
      for (int i = 0; i < 12; i++) send_motion(32'h7FFFFFFF);
      write_register(CSR_WHEEL_BASE_SUM, 25'd0);
      for (int i = 0; i < 8; i++) send_motion(32'h0100000);
      write_register(CSR_WHEEL_RADIUS, 25'd1);
      write_register(CSR_WHEEL_BASE_SUM, 25'd16777216);
      for (int i = 0; i < 8; i++) send_motion(32'h7FFFFFFF);
      write_register(CSR_WHEEL_RADIUS, 25'h1FFFFFF);
      write_register(CSR_WHEEL_BASE_SUM, 25'h1FFFFFF);
      for (int i = 0; i < 8; i++) send_motion(32'h0400000);
      write_register(CSR_WHEEL_RADIUS, 25'd3277);
      write_register(CSR_WHEEL_BASE_SUM, 25'd32768);
      send_word(make_word(KIND_RESET_POSE, '0, '0, '0, '0, '0));
   endtask

   // receiver holds off while short words pile up at the input
   task automatic test_backpressure();
      wait_drained();
      hold_ask = 1'b1;
      quiet = 1'b1;
      for (int i = 0; i < 10; i++)
         send_word(make_word(KIND_UPDATE, $urandom, $urandom, $urandom, $urandom,
                             stim_time + $urandom_range(0, 99)));
      send_motion(32'h20000);
      quiet = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_drive(int count);
      int p;
      for (int i = 0; i < count; i++) begin
         quiet = ((i / 100) % 4 == 3);
         p = $urandom_range(0, 99);
         if (p < 55) send_motion(32'h40000);
         else if (p < 62) send_motion(32'hFFFFFFFF);
         else if (p < 78)
            send_word(make_word(KIND_UPDATE, stim_angle[0] + $urandom_range(0, 9),
                                stim_angle[1], stim_angle[2], stim_angle[3],
                                stim_time + $urandom_range(0, 99)));
         else if (p < 82)
            send_word(make_word(KIND_UPDATE, $urandom, $urandom, $urandom, $urandom,
                                stim_time - $urandom_range(1, 100000)));
         else if (p < 86) send_init(stim_time + $urandom_range(0, 3000));
         else if (p < 90)
            send_word(make_word(KIND_RESET_POSE, $urandom, $urandom, $urandom,
                                $urandom, 48'({$urandom, $urandom})));
         else if (p < 93)
            send_word(make_word(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                48'({$urandom, $urandom})));
         else if (p < 96) begin
            for (int k = 0; k < 4; k++) stim_angle[k] = $urandom;
            send_word(make_word(KIND_UPDATE, stim_angle[0], stim_angle[1],
                                stim_angle[2], stim_angle[3],
                                stim_time + 100));
            stim_time = stim_time + 100;
         end else send_motion(32'h400);
      end
      quiet = 1'b0;
   endtask

   task automatic test_register_sweep();
      write_register(CSR_WHEEL_RADIUS, 25'(1 + $urandom_range(0, 16777215)));
      write_register(CSR_WHEEL_BASE_SUM, 25'(1 + $urandom_range(0, 16777215)));
      for (int i = 0; i < 30; i++) send_motion(32'h100000);
   endtask

   initial begin
      radius_q16 = 3277;
      base_q16 = 32768;
      for (int k = 0; k < 4; k++) begin
         prev_angle[k] = 0;
         stim_angle[k] = '0;
      end
      ref_time = '0;
      stim_time = '0;
      pos[0] = 0;
      pos[1] = 0;
      heading = '0;
      clear_windows();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random_drive(450);
      test_register_sweep();
      test_random_drive(400);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d words (%0d applied updates) and %0d results", words_sent,
               updates_taken, results_seen);
      $display("register extremes, zero separation, refusals and a long output hold");
      if (failures == 0 && expected_poses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ mecanum_wheel_odometry.f @@
+incdir+rtl
rtl/mwo_pkg.sv
rtl/mecanum_wheel_odometry.sv
tb/sv/mecanum_wheel_odometry_test.sv
